@@ design/frma_pkg.sv @@
// Package for the frame rate moving average block.
// Shared widths, reset values, limits and the queue status type.
// No dependencies.
`default_nettype none

package frma_pkg;

    localparam int WINDOW_DEF = 10;
    localparam int TPS_W      = 20;
    localparam int TICK_W     = 32;
    localparam int FT_W       = 16;
    localparam int AVG_W      = 24;
    localparam int RATE_W     = 34;
    localparam int Q_DEPTH    = 2;

    localparam logic [TPS_W-1:0]  TPS_RESET = 20'd1000;
    localparam logic [FT_W-1:0]   FT_MAX    = 16'hFFFF;
    localparam logic [RATE_W-1:0] RATE_MAX  = 34'h3_FFFF_FFFF;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

@@ design/frma_in_if.sv @@
// Input channel of the frame rate meter: one timestamp per item.
// Uses frma_pkg for the field width.
`default_nettype none

interface frma_in_if;
    logic                          valid;
    logic                          ready;
    logic [frma_pkg::TICK_W-1:0]   tick_time;

    modport source (output valid, output tick_time, input ready);
    modport sink   (input valid, input tick_time, output ready);
endinterface

`default_nettype wire

@@ design/frma_out_if.sv @@
// Result channel of the frame rate meter: frame time, average and rate.
// Uses frma_pkg for the field widths.
`default_nettype none

interface frma_out_if;
    logic                          valid;
    logic                          ready;
    logic [frma_pkg::FT_W-1:0]     frame_time;
    logic [frma_pkg::AVG_W-1:0]    average_frame_time;
    logic [frma_pkg::RATE_W-1:0]   frame_rate;

    modport source (output valid, output frame_time, output average_frame_time,
                    output frame_rate, input ready);
    modport sink   (input valid, input frame_time, input average_frame_time,
                    input frame_rate, output ready);
endinterface

`default_nettype wire

@@ design/frma_fifo.sv @@
// Short queue of frame times between the front and the back part.
// Depends on frma_pkg for depth, width and the status struct.
`default_nettype none

module frma_fifo (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic [frma_pkg::FT_W-1:0]   i_data,
    input  wire logic                        i_pop,
    output frma_pkg::t_q_stat                o_stat,
    output logic      [frma_pkg::FT_W-1:0]   o_data
);
    localparam int PW = (frma_pkg::Q_DEPTH > 1) ? $clog2(frma_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(frma_pkg::Q_DEPTH + 1);

    logic [frma_pkg::FT_W-1:0] r_mem [frma_pkg::Q_DEPTH];
    logic [PW-1:0]             r_wp;
    logic [PW-1:0]             r_rp;
    logic [CW-1:0]             r_cnt;
    logic                      w_push;
    logic                      w_pop;

    assign o_stat.full  = (r_cnt == CW'(frma_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(frma_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(frma_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

`default_nettype wire

@@ design/frma_front.sv @@
// Front part: accepts timestamps and forms the saturated frame time.
// Depends on frma_pkg and frma_in_if; feeds frma_fifo.
`default_nettype none

module frma_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    frma_in_if.sink                          i_item,
    input  wire frma_pkg::t_q_stat           i_q_stat,
    output logic                             o_push,
    output logic      [frma_pkg::FT_W-1:0]   o_ft
);
    logic [frma_pkg::TICK_W-1:0] r_prev;
    logic                        r_have;
    logic [frma_pkg::TICK_W-1:0] w_diff;

    assign i_item.ready = !i_q_stat.full;
    assign o_push       = i_item.valid && !i_q_stat.full;
    assign w_diff       = i_item.tick_time - r_prev;

    always_comb begin
        if (!r_have) begin
            o_ft = '0;
        end else if (|w_diff[frma_pkg::TICK_W-1:frma_pkg::FT_W]) begin
            o_ft = frma_pkg::FT_MAX;
        end else begin
            o_ft = w_diff[frma_pkg::FT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_have <= 1'b0;
        end else if (o_push) begin
            r_prev <= i_item.tick_time;
            r_have <= 1'b1;
        end
    end
endmodule

`default_nettype wire

@@ design/frma_div.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies; used twice by frma_back.
`default_nettype none

module frma_div #(
    parameter int N_W = 32,
    parameter int D_W = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [N_W-1:0]   i_num,
    input  wire logic [D_W-1:0]   i_den,
    output logic                  o_busy,
    output logic      [N_W-1:0]   o_quot
);
    localparam int CW = $clog2(N_W + 1);

    logic [D_W-1:0] r_rem;
    logic [N_W-1:0] r_quot;
    logic [D_W-1:0] r_den;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic [D_W:0]   w_sh;
    logic [D_W:0]   w_sub;
    logic           w_ge;

    assign w_sh   = {r_rem, r_quot[N_W-1]};
    assign w_sub  = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[D_W-1:0] : w_sh[D_W-1:0];
            r_quot <= {r_quot[N_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

`default_nettype wire

@@ design/frma_back.sv @@
// Back part: ring of frame times, running sum, both divisions, result register.
// Depends on frma_pkg, frma_out_if and frma_div.
`default_nettype none

module frma_back #(
    parameter int WINDOW = frma_pkg::WINDOW_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [frma_pkg::TPS_W-1:0]   i_tps,
    input  wire logic [frma_pkg::FT_W-1:0]    i_q_data,
    input  wire frma_pkg::t_q_stat            i_q_stat,
    output logic                              o_q_pop,
    frma_out_if.source                        o_result
);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = frma_pkg::FT_W + CNT_W;
    localparam int AN_W  = SUM_W + 8;
    localparam int PR_W  = frma_pkg::TPS_W + CNT_W;
    localparam int RN_W  = PR_W + 8;
    localparam int EXT_W = (RN_W > frma_pkg::RATE_W) ? RN_W : frma_pkg::RATE_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_DIV  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_bstate;

    t_bstate                     r_state;
    t_bstate                     n_state;
    logic [frma_pkg::FT_W-1:0]   r_ring [WINDOW];
    logic [frma_pkg::FT_W-1:0]   r_old;
    logic [frma_pkg::FT_W-1:0]   r_ft;
    logic [IDX_W-1:0]            r_slot;
    logic [CNT_W-1:0]            r_count;
    logic [SUM_W-1:0]            r_sum;
    logic [SUM_W-1:0]            n_sum;
    logic                        w_full;
    logic                        w_load;
    logic                        w_start;
    logic [PR_W-1:0]             w_prod;
    logic                        w_a_busy;
    logic                        w_r_busy;
    logic [AN_W-1:0]             w_a_quot;
    logic [RN_W-1:0]             w_r_quot;
    logic [EXT_W-1:0]            w_r_ext;
    logic [frma_pkg::RATE_W-1:0] w_rate;
    logic                        r_ovalid;
    logic [frma_pkg::FT_W-1:0]   r_o_ft;
    logic [frma_pkg::AVG_W-1:0]  r_o_avg;
    logic [frma_pkg::RATE_W-1:0] r_o_rate;

    assign w_full  = (r_count == CNT_W'(WINDOW));
    assign o_q_pop = (r_state == S_IDLE) && !i_q_stat.empty;
    assign w_start = (r_state == S_DIV);
    assign w_load  = (r_state == S_OUT) && (!r_ovalid || o_result.ready);
    assign w_prod  = PR_W'(i_tps) * PR_W'(r_count);
    assign n_sum   = r_sum - (w_full ? SUM_W'(r_old) : '0) + SUM_W'(r_ft);
    assign w_r_ext = EXT_W'(w_r_quot);

    always_comb begin
        if (r_sum == '0) begin
            w_rate = '0;
        end else if (w_r_ext > EXT_W'(frma_pkg::RATE_MAX)) begin
            w_rate = frma_pkg::RATE_MAX;
        end else begin
            w_rate = w_r_ext[frma_pkg::RATE_W-1:0];
        end
    end

    frma_div #(.N_W(AN_W), .D_W(CNT_W)) u_div_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   ({r_sum, 8'b0}),
        .i_den   (r_count),
        .o_busy  (w_a_busy),
        .o_quot  (w_a_quot)
    );

    frma_div #(.N_W(RN_W), .D_W(SUM_W)) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   ({w_prod, 8'b0}),
        .i_den   (r_sum),
        .o_busy  (w_r_busy),
        .o_quot  (w_r_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = S_UPD;
                end
            end
            S_UPD:  n_state = S_DIV;
            S_DIV:  n_state = S_WAIT;
            S_WAIT: begin
                if (!w_a_busy && !w_r_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ring memory, registered read of the entry at the current slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_ring[r_slot] <= r_ft;
        end
        r_old <= r_ring[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ft <= i_q_data;
        end
        if (w_load) begin
            r_o_ft   <= r_ft;
            r_o_avg  <= w_a_quot[frma_pkg::AVG_W-1:0];
            r_o_rate <= w_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                r_sum  <= n_sum;
                r_slot <= (r_slot == IDX_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (!w_full) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_result.valid              = r_ovalid;
    assign o_result.frame_time         = r_o_ft;
    assign o_result.average_frame_time = r_o_avg;
    assign o_result.frame_rate         = r_o_rate;
endmodule

`default_nettype wire

@@ design/frame_rate_moving_average.sv @@
// Top level of the moving average frame rate meter.
// Depends on frma_pkg, frma_in_if, frma_out_if, frma_front, frma_fifo, frma_back.
//
//   channel   dir   item fields
//   i_item    in    tick_time[31:0]
//   o_result  out   frame_time[15:0], average_frame_time[23:0], frame_rate[33:0]
//   i_cfg_*   in    ticks_per_second[19:0], written when i_cfg_we is high
//
// The back part takes one item at a time; the bit-serial rate divider, the
// wider of its two dividers, sets how long each item takes; the front takes an item
// a cycle until the two-entry queue fills.
// Reset is synchronous, active low, and clears all control state.
// A valid result is held while o_result.ready is low; the back part goes on
// with the next queued item meanwhile, then waits until the register is taken.
`default_nettype none

module frame_rate_moving_average #(
    parameter int WINDOW = frma_pkg::WINDOW_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [frma_pkg::TPS_W-1:0]   i_cfg_wdata,
    frma_in_if.sink                           i_item,
    frma_out_if.source                        o_result
);
    logic [frma_pkg::TPS_W-1:0] r_tps;
    logic                       w_push;
    logic                       w_pop;
    logic [frma_pkg::FT_W-1:0]  w_push_ft;
    logic [frma_pkg::FT_W-1:0]  w_pop_ft;
    frma_pkg::t_q_stat          w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= frma_pkg::TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    frma_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_ft     (w_push_ft)
    );

    frma_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_ft),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_data  (w_pop_ft)
    );

    frma_back #(.WINDOW(WINDOW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tps    (r_tps),
        .i_q_data (w_pop_ft),
        .i_q_stat (w_q_stat),
        .o_q_pop  (w_pop),
        .o_result (o_result)
    );
endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for frame_rate_moving_average: directed table, then random timestamps.
// Each result is checked against its table value if known, else a built-in model.
// Depends on frma_pkg, frma_in_if, frma_out_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
    localparam int WIN         = frma_pkg::WINDOW_DEF;
    localparam int TICK_W      = frma_pkg::TICK_W;
    localparam int TPS_W       = frma_pkg::TPS_W;
    localparam int FT_W        = frma_pkg::FT_W;
    localparam int AVG_W       = frma_pkg::AVG_W;
    localparam int RATE_W      = frma_pkg::RATE_W;
    localparam int N_PHASES    = 6;
    localparam int PHASE_LEN   = 64;
    localparam int SETTLE      = 60;
    localparam int HOLD_LEN    = 300;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [FT_W-1:0]   ft;
        logic [AVG_W-1:0]  avg;
        logic [RATE_W-1:0] rate;
    } t_meter_result;

    typedef struct {
        logic [TICK_W-1:0] stamp;
        logic              known;
        t_meter_result     res;
    } t_step_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TPS_W-1:0] i_cfg_wdata;

    frma_in_if  in_ch ();
    frma_out_if res_ch ();

    frame_rate_moving_average #(
        .WINDOW (WIN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (in_ch),
        .o_result    (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic [TPS_W-1:0]  rate_tps = frma_pkg::TPS_RESET;
    logic [TICK_W-1:0] last_tick = '0;
    logic              seen_first = 1'b0;
    logic [FT_W-1:0]   frame_ring [WIN];
    int                ring_pos = 0;
    int                ring_fill = 0;
    int                ring_total = 0;

    t_meter_result expected_q [$];
    t_step_row     pending_rows [$];
    t_step_row     dir_rows [$];
    int            fails = 0;
    int            idle_cycles = 0;
    int            gap_max = 0;
    int            stall_pct = 0;
    int            burst_left = 0;
    logic          hold_req = 1'b0;

    function automatic t_meter_result meter_advance(input logic [TICK_W-1:0] stamp);
        logic [TICK_W-1:0] gap_ticks;
        logic [FT_W-1:0]   ft;
        logic [63:0]       quo;
        t_meter_result     r;
        gap_ticks = seen_first ? stamp - last_tick : '0;
        ft = (gap_ticks > TICK_W'(frma_pkg::FT_MAX)) ? frma_pkg::FT_MAX : gap_ticks[FT_W-1:0];
        last_tick = stamp;
        seen_first = 1'b1;
        if (ring_fill >= WIN)
            ring_total -= frame_ring[ring_pos];
        else
            ring_fill++;
        frame_ring[ring_pos] = ft;
        ring_total += ft;
        ring_pos = (ring_pos + 1 >= WIN) ? 0 : ring_pos + 1;
        r.ft = ft;
        quo = (64'(ring_total) << 8) / 64'(ring_fill);
        r.avg = quo[AVG_W-1:0];
        if (ring_total == 0) begin
            r.rate = '0;
        end else begin
            quo = ((64'(rate_tps) * 64'(ring_fill)) << 8) / 64'(ring_total);
            r.rate = (quo > 64'(frma_pkg::RATE_MAX)) ? frma_pkg::RATE_MAX : quo[RATE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [TICK_W-1:0] next_stamp(input logic [TICK_W-1:0] prev);
        case ($urandom_range(0, 9))
            0:             return prev;
            1, 2, 3, 4, 5: return prev + $urandom_range(1, 100);
            6, 7:          return prev + $urandom_range(101, 20000);
            8:             return prev + $urandom_range(60000, 70000);
            default:       return $urandom;
        endcase
    endfunction

    task automatic offer_tick(input t_step_row row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.tick_time <= row.stamp;
        pending_rows = {pending_rows, row};
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain(input int settle);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_q.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_tps(input logic [TPS_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rate_tps = value;
    endtask

    // item and result monitor
    always @(posedge i_clk) begin : monitor
        t_step_row     row;
        t_meter_result pred;
        t_meter_result want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                row  = pending_rows.pop_front();
                pred = meter_advance(in_ch.tick_time);
                want = row.known ? row.res : pred;
                expected_q = {expected_q, want};
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no item pending");
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (res_ch.frame_time !== want.ft) begin
                        $error("frame_time: expected %0d, got %0d", want.ft, res_ch.frame_time);
                        fails++;
                    end
                    if (res_ch.average_frame_time !== want.avg) begin
                        $error("average_frame_time: expected %0d, got %0d",
                               want.avg, res_ch.average_frame_time);
                        fails++;
                    end
                    if (res_ch.frame_rate !== want.rate) begin
                        $error("frame_rate: expected %0d, got %0d",
                               want.rate, res_ch.frame_rate);
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side stalls
    initial begin
        int   run_left;
        int   hold_left;
        logic rdy_now;
        run_left  = 0;
        hold_left = 0;
        rdy_now   = 1'b1;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 8);
                    rdy_now  = ($urandom_range(0, 99) >= stall_pct);
                end
                run_left--;
                res_ch.ready <= rdy_now;
            end
        end
    end

    initial begin
        logic [TPS_W-1:0] tps_list [N_PHASES];
        int               gap_list [N_PHASES];
        int               stall_list [N_PHASES];
        t_step_row        row;
        logic [TICK_W-1:0] stamp;
        in_ch.valid     <= 1'b0;
        in_ch.tick_time <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_rst_n         <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first item, a short frame, a zero frame; wrap and saturation; full
        // ring of saturated frame times; full ring of zero frame times
        dir_rows = {dir_rows, t_step_row'{32'h0000_1000, 1'b1, '{16'd0, 24'd0, 34'd0}}};
        dir_rows = {dir_rows,
                    t_step_row'{32'h0000_1010, 1'b1, '{16'd16, 24'd2048, 34'd32000}}};
        dir_rows = {dir_rows, t_step_row'{32'h0000_1010, 1'b0, '0}};
        dir_rows = {dir_rows, t_step_row'{32'hFFFF_FFFF, 1'b0, '0}};
        dir_rows = {dir_rows, t_step_row'{32'h0000_0000, 1'b0, '0}};
        for (int k = 1; k <= WIN; k++)
            dir_rows = {dir_rows, t_step_row'{k * 32'h0002_0000, k == WIN,
                                  '{frma_pkg::FT_MAX, 24'hFFFF00, 34'd3}}};
        for (int k = 1; k <= WIN; k++)
            dir_rows = {dir_rows, t_step_row'{WIN * 32'h0002_0000, k == WIN,
                                  '{16'd0, 24'd0, 34'd0}}};

        gap_max   = 3;
        stall_pct = 25;
        foreach (dir_rows[i])
            offer_tick(dir_rows[i]);
        stamp = dir_rows[dir_rows.size() - 1].stamp;

        tps_list   = '{frma_pkg::TPS_RESET, 20'd1, 20'd1000000, 20'd0, 20'hFFFFF,
                       TPS_W'($urandom_range(1, 1000000))};
        gap_list   = '{0, 6, 1, 20, 8, 12};
        stall_list = '{0, 30, 20, 50, 10, 40};
        for (int p = 0; p < N_PHASES; p++) begin
            drain(SETTLE);
            write_tps(tps_list[p]);
            gap_max   = gap_list[p];
            stall_pct = stall_list[p];
            if (p == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (p == 3 && i == PHASE_LEN / 2)
                    drain(0);
                stamp     = next_stamp(stamp);
                row.stamp = stamp;
                row.known = 1'b0;
                row.res   = '0;
                offer_tick(row);
            end
        end

        drain(SETTLE);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/frma_pkg.sv
design/frma_in_if.sv
design/frma_out_if.sv
design/frma_fifo.sv
design/frma_front.sv
design/frma_div.sv
design/frma_back.sv
design/frame_rate_moving_average.sv
verif/tb_top.sv
